// ===== hdl/switch_fade_ramp_generator_core_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies
`ifndef SWITCH_FADE_RAMP_GENERATOR_CORE_MACROS_SVH
`define SWITCH_FADE_RAMP_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define SFRG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfrg check failed");

// next-cycle implication
`define SFRG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfrg check failed");

`endif

// ===== hdl/sfrg_pkg.sv =====
// shared types, constants and ramp step functions for the fade ramp generator
// no dependencies
package sfrg_pkg;

   localparam int LEVEL_W     = 16;
   localparam int STEP_W      = 16;
   localparam int SCALE       = 1000;
   localparam int SCALE_W     = 10;
   localparam int NUM_W       = STEP_W + SCALE_W;
   localparam int TICK_RATE_DEF = 1000;

   localparam logic [15:0] MS_MIN = 16'd20;

   localparam logic [2:0] REG_CHANNEL    = 3'd0;
   localparam logic [2:0] REG_CONTROLLER = 3'd1;
   localparam logic [2:0] REG_START      = 3'd2;
   localparam logic [2:0] REG_HOLD       = 3'd3;
   localparam logic [2:0] REG_END        = 3'd4;
   localparam logic [2:0] REG_FADE_IN    = 3'd5;
   localparam logic [2:0] REG_FADE_OUT   = 3'd6;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SWITCH = 1'b1;

   localparam logic [15:0] SW_RELEASE = 16'd0;
   localparam logic [15:0] SW_PRESS   = 16'd1;

   localparam logic [1:0] PH_IN   = 2'd0;
   localparam logic [1:0] PH_FALL = 2'd1;
   localparam logic [1:0] PH_RISE = 2'd2;

   typedef struct packed {
      logic                start;
   } div_ctl_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [STEP_W-1:0]   quot;
   } div_sts_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [6:0]          value;
      logic                done;
   } tick_res_type;

   function automatic tick_res_type rise_tick(logic [LEVEL_W-1:0] level,
                                              logic [STEP_W-1:0] step,
                                              logic [6:0] target);
      tick_res_type r;
      logic [LEVEL_W-1:0] sum;
      logic [LEVEL_W-1:0] t14;
      t14 = {2'b00, target, 7'b0};
      sum = level + step;
      r.level = sum;
      if (sum < t14) begin
         r.value = sum[13:7];
         r.done  = 1'b0;
      end else begin
         r.value = target;
         r.done  = 1'b1;
      end
      return r;
   endfunction

   function automatic tick_res_type fall_tick(logic [LEVEL_W-1:0] level,
                                              logic [STEP_W-1:0] step,
                                              logic [6:0] target);
      tick_res_type r;
      logic [LEVEL_W-1:0] nv;
      logic [LEVEL_W-1:0] t14;
      t14 = {2'b00, target, 7'b0};
      nv = level - step;
      r.level = level;
      r.value = target;
      r.done  = 1'b1;
      if (step <= level) begin
         r.level = nv;
         if (nv > t14 && step < nv && nv[13:7] != target) begin
            r.value = nv[13:7];
            r.done  = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/switch_fade_ramp_generator_core.sv =====
// switch driven control change fade ramp, top level with sequencer and state
// depends on sfrg_pkg and sfrg_div
//
// req channel: req_operation selects a tick (0) or a switch write (1) with
// req_switch_value; an item is taken when req_valid is high and req_stall low.
// rsp channel: one control change (channel, controller, value) per tick that
// emits; it sits in an output register until taken (rsp_valid, not rsp_stall).
// csr channel: register writes by index, taken when csr_valid and csr_ready.
// a taken tick's item appears on rsp in the next cycle; a tick can be taken
// every cycle while the output register drains and no register write waits.
// a release that needs a new step and every register write to indexes 0 to 6
// run the shared serial divider; a register write derives the rise step and
// then the fall step, a release only the fall step.
// meanwhile req_stall is high and csr_ready low.
// reset is synchronous: control registers and ramp state go to zero, rsp data
// registers are not. while rsp_stall holds a pending item, req_stall stays high.
module switch_fade_ramp_generator_core #(
   parameter int TICK_RATE = sfrg_pkg::TICK_RATE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_switch_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_out_channel,
   output logic [6:0]  rsp_out_controller,
   output logic [6:0]  rsp_out_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import sfrg_pkg::*;

   localparam int DEN_W = STEP_W + $clog2(TICK_RATE + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LR    = 3'd1;
   localparam logic [2:0] S_WR    = 3'd2;
   localparam logic [2:0] S_LF    = 3'd3;
   localparam logic [2:0] S_WF    = 3'd4;
   localparam logic [2:0] S_LREL  = 3'd5;
   localparam logic [2:0] S_WREL  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  chan_ff, chan_in;
   logic [6:0]  ctrl_ff, ctrl_in;
   logic [6:0]  start_ff, start_in;
   logic [6:0]  hold_ff, hold_in;
   logic [6:0]  end_ff, end_in;
   logic [15:0] fade_in_ff, fade_in_in;
   logic [15:0] fade_out_ff, fade_out_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [STEP_W-1:0]  rise_step_ff, rise_step_in;
   logic [STEP_W-1:0]  fall_step_ff, fall_step_in;
   logic [1:0]  phase_ff, phase_in;
   logic        rise_act_ff, rise_act_in;
   logic        fall_act_ff, fall_act_in;
   logic [15:0] last_sw_ff, last_sw_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_chan_ff, rsp_chan_in;
   logic [6:0]  rsp_ctrl_ff, rsp_ctrl_in;
   logic [6:0]  rsp_value_ff, rsp_value_in;

   div_ctl_type        div_ctl;
   div_sts_type        div_sts;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic [LEVEL_W-1:0] delta;
   logic [15:0]        ms_sel;
   logic [LEVEL_W-1:0] s14, h14, e14;
   logic [STEP_W-1:0]  step_sel;
   logic [6:0]         tgt_sel;
   tick_res_type       tr_up, tr_dn, tr;
   logic               req_take;
   logic               emit;
   logic [6:0]         emit_value;

   assign s14 = {2'b00, start_ff, 7'b0};
   assign h14 = {2'b00, hold_ff, 7'b0};
   assign e14 = {2'b00, end_ff, 7'b0};

   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall) || csr_valid;
   assign req_take  = req_valid && !req_stall;

   // divider operands
   always_comb begin
      case (state_ff)
         S_LR: begin
            delta  = (s14 > h14) ? (s14 - h14) : (h14 - s14);
            ms_sel = fade_in_ff;
         end
         S_LF: begin
            delta  = (e14 > h14) ? (e14 - h14) : (h14 - e14);
            ms_sel = fade_out_ff;
         end
         S_LREL: begin
            delta  = (e14 > level_ff) ? (e14 - level_ff) : (level_ff - e14);
            ms_sel = fade_out_ff;
         end
         default: begin
            delta  = '0;
            ms_sel = fade_out_ff;
         end
      endcase
      div_num = NUM_W'(delta) * NUM_W'(SCALE);
      div_den = DEN_W'(ms_sel) * DEN_W'(TICK_RATE);
   end

   // one ramp step
   always_comb begin
      step_sel = (phase_ff == PH_IN) ? rise_step_ff : fall_step_ff;
      tgt_sel  = (phase_ff == PH_IN) ? hold_ff : end_ff;
      tr_up    = rise_tick(level_ff, step_sel, tgt_sel);
      tr_dn    = fall_tick(level_ff, step_sel, tgt_sel);
      if (phase_ff == PH_IN)
         tr = (start_ff < hold_ff) ? tr_up : tr_dn;
      else
         tr = (phase_ff == PH_RISE) ? tr_up : tr_dn;
   end

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      ctrl_in      = ctrl_ff;
      start_in     = start_ff;
      hold_in      = hold_ff;
      end_in       = end_ff;
      fade_in_in   = fade_in_ff;
      fade_out_in  = fade_out_ff;
      level_in     = level_ff;
      rise_step_in = rise_step_ff;
      fall_step_in = fall_step_ff;
      phase_in     = phase_ff;
      rise_act_in  = rise_act_ff;
      fall_act_in  = fall_act_ff;
      last_sw_in   = last_sw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_chan_in  = rsp_chan_ff;
      rsp_ctrl_in  = rsp_ctrl_ff;
      rsp_value_in = rsp_value_ff;
      div_ctl.start = 1'b0;
      emit         = 1'b0;
      emit_value   = tr.value;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               state_in = S_LR;
               case (csr_index)
                  REG_CHANNEL:    chan_in     = csr_data[3:0];
                  REG_CONTROLLER: ctrl_in     = csr_data[6:0];
                  REG_START:      start_in    = csr_data[6:0];
                  REG_HOLD:       hold_in     = csr_data[6:0];
                  REG_END:        end_in      = csr_data[6:0];
                  REG_FADE_IN:    fade_in_in  = csr_data;
                  REG_FADE_OUT:   fade_out_in = csr_data;
                  default:        state_in    = S_IDLE;
               endcase
            end else if (req_take) begin
               if (req_operation == OP_SWITCH) begin
                  if (req_switch_value != last_sw_ff) begin
                     last_sw_in = req_switch_value;
                     if (req_switch_value == SW_PRESS) begin
                        phase_in    = PH_IN;
                        rise_act_in = 1'b1;
                        fall_act_in = 1'b0;
                        level_in    = s14;
                     end else if (req_switch_value == SW_RELEASE) begin
                        if (fade_out_ff >= MS_MIN && end_ff != hold_ff) begin
                           if (e14 < level_ff && phase_ff != PH_FALL) begin
                              phase_in = PH_FALL;
                              state_in = S_LREL;
                           end
                           if (e14 > level_ff && phase_ff != PH_RISE) begin
                              phase_in = PH_RISE;
                              state_in = S_LREL;
                           end
                        end else begin
                           phase_in = PH_FALL;
                        end
                        rise_act_in = 1'b0;
                        fall_act_in = 1'b1;
                     end
                  end
               end else begin
                  if (phase_ff == PH_IN) begin
                     if (rise_act_ff) begin
                        if (fade_in_ff < MS_MIN) begin
                           level_in    = h14;
                           rise_act_in = 1'b0;
                           emit        = 1'b1;
                           emit_value  = hold_ff;
                        end else if (start_ff != hold_ff) begin
                           emit = 1'b1;
                           if (tr.done) begin
                              level_in    = h14;
                              rise_act_in = 1'b0;
                           end else begin
                              level_in = tr.level;
                           end
                        end
                     end
                  end else if (phase_ff == PH_FALL || phase_ff == PH_RISE) begin
                     if (fall_act_ff) begin
                        if (fade_out_ff < MS_MIN) begin
                           fall_act_in = 1'b0;
                           emit        = 1'b1;
                           emit_value  = end_ff;
                        end else begin
                           emit     = 1'b1;
                           level_in = tr.level;
                           if (tr.done)
                              fall_act_in = 1'b0;
                        end
                     end
                  end
               end
            end
         end
         S_LR: begin
            div_ctl.start = 1'b1;
            state_in      = S_WR;
         end
         S_WR: begin
            if (div_sts.done) begin
               rise_step_in = (fade_in_ff >= MS_MIN) ? div_sts.quot : '0;
               state_in     = S_LF;
            end
         end
         S_LF: begin
            div_ctl.start = 1'b1;
            state_in      = S_WF;
         end
         S_WF: begin
            if (div_sts.done) begin
               fall_step_in = (fade_out_ff >= MS_MIN && end_ff != hold_ff) ?
                              div_sts.quot : '0;
               state_in     = S_IDLE;
            end
         end
         S_LREL: begin
            div_ctl.start = 1'b1;
            state_in      = S_WREL;
         end
         S_WREL: begin
            if (div_sts.done) begin
               fall_step_in = div_sts.quot;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_chan_in  = chan_ff;
         rsp_ctrl_in  = ctrl_ff;
         rsp_value_in = emit_value;
      end
   end

   sfrg_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      rsp_chan_ff  <= rsp_chan_in;
      rsp_ctrl_ff  <= rsp_ctrl_in;
      rsp_value_ff <= rsp_value_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= '0;
         ctrl_ff      <= '0;
         start_ff     <= '0;
         hold_ff      <= '0;
         end_ff       <= '0;
         fade_in_ff   <= '0;
         fade_out_ff  <= '0;
         level_ff     <= '0;
         rise_step_ff <= '0;
         fall_step_ff <= '0;
         phase_ff     <= PH_IN;
         rise_act_ff  <= 1'b0;
         fall_act_ff  <= 1'b0;
         last_sw_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         ctrl_ff      <= ctrl_in;
         start_ff     <= start_in;
         hold_ff      <= hold_in;
         end_ff       <= end_in;
         fade_in_ff   <= fade_in_in;
         fade_out_ff  <= fade_out_in;
         level_ff     <= level_in;
         rise_step_ff <= rise_step_in;
         fall_step_ff <= fall_step_in;
         phase_ff     <= phase_in;
         rise_act_ff  <= rise_act_in;
         fall_act_ff  <= fall_act_in;
         last_sw_ff   <= last_sw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_chan_ff;
   assign rsp_out_controller = rsp_ctrl_ff;
   assign rsp_out_value      = rsp_value_ff;

endmodule

// ===== hdl/sfrg_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on sfrg_pkg
module sfrg_div #(
   parameter int NUM_W = sfrg_pkg::NUM_W,
   parameter int DEN_W = sfrg_pkg::NUM_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sfrg_pkg::div_ctl_type    ctl,
   input  logic [NUM_W-1:0]         num,
   input  logic [DEN_W-1:0]         den,
   output sfrg_pkg::div_sts_type    sts
);
   import sfrg_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      if (ctl.start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quot = quo_ff[STEP_W-1:0];

endmodule

// ===== hdl/sfrg_checker.sv =====
// port-level checks for the fade ramp generator, bound to the top level
// depends on sfrg_pkg and switch_fade_ramp_generator_core_macros.svh
`include "switch_fade_ramp_generator_core_macros.svh"

module sfrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_out_value,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index
);
   import sfrg_pkg::*;

   // a stalled item holds
   `SFRG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_value))

   // a new item only follows an accepted tick
   `SFRG_ASSERT_NOW(a_rsp_from_tick, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall && req_operation == OP_TICK))

   // switch writes emit nothing
   `SFRG_ASSERT_NEXT(a_switch_silent, clock, reset,
      req_valid && !req_stall && req_operation == OP_SWITCH && !rsp_valid, !rsp_valid)

   // a register write starts step derivation
   `SFRG_ASSERT_NEXT(a_csr_busy, clock, reset,
      csr_valid && csr_ready && csr_index <= REG_FADE_OUT, req_stall && !csr_ready)

   // while the divider runs no item is taken
   `SFRG_ASSERT_NOW(a_busy_stall, clock, reset, !csr_ready, req_stall)

endmodule

bind switch_fade_ramp_generator_core sfrg_checker u_sfrg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready),
   .csr_index     (csr_index)
);

// ===== tb/fade_ramp_checker.sv =====
// checker for the fade ramp generator: tracks register writes and items on the
// req, rsp and csr channels, predicts each control change and compares it
// depends on sfrg_pkg
module fade_ramp_checker #(
   parameter int TICK_RATE = sfrg_pkg::TICK_RATE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_switch_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_out_channel,
   input  logic [6:0]  rsp_out_controller,
   input  logic [6:0]  rsp_out_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import sfrg_pkg::*;

   typedef struct packed {
      logic [3:0] channel;
      logic [6:0] controller;
      logic [6:0] value;
   } cc_msg_type;

   cc_msg_type cc_expected[$];

   logic [3:0]  cfg_channel;
   logic [6:0]  cfg_ctrl;
   logic [6:0]  cfg_start;
   logic [6:0]  cfg_hold;
   logic [6:0]  cfg_end;
   logic [15:0] cfg_in_ms;
   logic [15:0] cfg_out_ms;

   logic [15:0] level;
   logic [15:0] up_step;
   logic [15:0] down_step;
   logic [15:0] last_sw;
   logic [1:0]  phase;
   logic        rise_on;
   logic        fall_on;

   function automatic logic [15:0] lvl14(logic [6:0] v);
      return {2'b00, v, 7'd0};
   endfunction

   function automatic logic [15:0] ramp_rate(logic [15:0] span, logic [15:0] ms);
      logic [63:0] den;
      logic [63:0] quo;
      den = 64'(TICK_RATE) * 64'(ms);
      if (den == 64'd0)
         return 16'd0;
      quo = (64'(span) * 64'(SCALE)) / den;
      return quo[15:0];
   endfunction

   function automatic void rederive();
      logic [15:0] s;
      logic [15:0] h;
      logic [15:0] e;
      s = lvl14(cfg_start);
      h = lvl14(cfg_hold);
      e = lvl14(cfg_end);
      up_step = '0;
      if (cfg_in_ms >= MS_MIN)
         up_step = ramp_rate(s > h ? s - h : h - s, cfg_in_ms);
      down_step = '0;
      if (cfg_out_ms >= MS_MIN && e != h)
         down_step = ramp_rate(e > h ? e - h : h - e, cfg_out_ms);
   endfunction

   function automatic void clear_model();
      cfg_channel = '0;
      cfg_ctrl    = '0;
      cfg_start   = '0;
      cfg_hold    = '0;
      cfg_end     = '0;
      cfg_in_ms   = '0;
      cfg_out_ms  = '0;
      level       = '0;
      up_step     = '0;
      down_step   = '0;
      last_sw     = '0;
      phase       = PH_IN;
      rise_on     = 1'b0;
      fall_on     = 1'b0;
   endfunction

   function automatic void write_cfg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         REG_CHANNEL:    cfg_channel = data[3:0];
         REG_CONTROLLER: cfg_ctrl    = data[6:0];
         REG_START:      cfg_start   = data[6:0];
         REG_HOLD:       cfg_hold    = data[6:0];
         REG_END:        cfg_end     = data[6:0];
         REG_FADE_IN:    cfg_in_ms   = data;
         REG_FADE_OUT:   cfg_out_ms  = data;
         default:        return;
      endcase
      rederive();
   endfunction

   function automatic void queue_cc(logic [6:0] v);
      cc_expected.push_back('{cfg_channel, cfg_ctrl, v});
   endfunction

   // upward step, done once the target is reached
   function automatic void climb(input logic [15:0] step, input logic [6:0] target,
                                 output logic [6:0] val, output logic fin);
      logic [15:0] goal;
      goal  = lvl14(target);
      level = level + step;
      if (level < goal) begin
         val = level[13:7];
         fin = 1'b0;
      end else begin
         val = target;
         fin = 1'b1;
      end
   endfunction

   // downward step, an underflow counts as reaching the target
   function automatic void drop(input logic [15:0] step, input logic [6:0] target,
                                output logic [6:0] val, output logic fin);
      logic [15:0] goal;
      logic [15:0] nxt;
      goal = lvl14(target);
      val  = target;
      fin  = 1'b1;
      if (step <= level) begin
         nxt   = level - step;
         level = nxt;
         if (nxt > goal && step < nxt && nxt[13:7] != target) begin
            val = nxt[13:7];
            fin = 1'b0;
         end
      end
   endfunction

   function automatic void apply_item(logic op, logic [15:0] sw);
      logic [15:0] e;
      logic [6:0]  val;
      logic        fin;
      if (op == OP_SWITCH) begin
         if (sw == last_sw)
            return;
         last_sw = sw;
         if (sw == SW_PRESS) begin
            phase   = PH_IN;
            rise_on = 1'b1;
            fall_on = 1'b0;
            level   = lvl14(cfg_start);
         end else if (sw == SW_RELEASE) begin
            e = lvl14(cfg_end);
            if (cfg_out_ms >= MS_MIN && cfg_end != cfg_hold) begin
               if (e < level && phase != PH_FALL) begin
                  down_step = ramp_rate(level - e, cfg_out_ms);
                  phase     = PH_FALL;
               end
               if (e > level && phase != PH_RISE) begin
                  down_step = ramp_rate(e - level, cfg_out_ms);
                  phase     = PH_RISE;
               end
            end else begin
               phase = PH_FALL;
            end
            rise_on = 1'b0;
            fall_on = 1'b1;
         end
         return;
      end
      fin = 1'b0;
      val = '0;
      case (phase)
         PH_IN: begin
            if (!rise_on)
               return;
            if (cfg_in_ms < MS_MIN) begin
               level   = lvl14(cfg_hold);
               rise_on = 1'b0;
               queue_cc(cfg_hold);
               return;
            end
            if (cfg_start < cfg_hold)
               climb(up_step, cfg_hold, val, fin);
            else if (cfg_start > cfg_hold)
               drop(up_step, cfg_hold, val, fin);
            else
               return;
            if (fin) begin
               level   = lvl14(cfg_hold);
               rise_on = 1'b0;
            end
            queue_cc(val);
         end
         PH_FALL, PH_RISE: begin
            if (!fall_on)
               return;
            if (cfg_out_ms < MS_MIN) begin
               fall_on = 1'b0;
               queue_cc(cfg_end);
               return;
            end
            if (phase == PH_FALL)
               drop(down_step, cfg_end, val, fin);
            else
               climb(down_step, cfg_end, val, fin);
            if (fin)
               fall_on = 1'b0;
            queue_cc(val);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_cc();
      cc_msg_type want;
      if (cc_expected.size() == 0) begin
         $error("control change with nothing expected: channel %0d controller %0d value %0d",
                rsp_out_channel, rsp_out_controller, rsp_out_value);
         fail_count++;
         return;
      end
      want = cc_expected.pop_front();
      results_checked++;
      if (rsp_out_channel !== want.channel) begin
         $error("out_channel expected %0d got %0d", want.channel, rsp_out_channel);
         fail_count++;
      end
      if (rsp_out_controller !== want.controller) begin
         $error("out_controller expected %0d got %0d", want.controller, rsp_out_controller);
         fail_count++;
      end
      if (rsp_out_value !== want.value) begin
         $error("out_value expected %0d got %0d", want.value, rsp_out_value);
         fail_count++;
      end
   endfunction

   initial begin
      fail_count      = 0;
      results_checked = 0;
      pending         = 0;
      clear_model();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         cc_expected.delete();
      end else begin
         if (csr_valid && csr_ready)
            write_cfg(csr_index, csr_data);
         if (rsp_valid && !rsp_stall)
            check_cc();
         if (req_valid && !req_stall)
            apply_item(req_operation, req_switch_value);
      end
      pending <= cc_expected.size();
   end

endmodule

// ===== tb/switch_fade_ramp_generator_core_tb.sv =====
// top of the fade ramp generator testbench: clock, reset, register setups,
// switch and tick items, random idling on both channels and the verdict
// depends on sfrg_pkg, switch_fade_ramp_generator_core and fade_ramp_checker
module switch_fade_ramp_generator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfrg_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int GESTURE_ITEMS = 700;
   localparam int DRAIN_CYCLES  = 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [15:0] req_switch_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_out_channel;
   logic [6:0]  rsp_out_controller;
   logic [6:0]  rsp_out_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int fail_count;
   int pending;
   int results_checked;
   int items_sent;
   int noise_items;
   int setups;
   bit calm;

   switch_fade_ramp_generator_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_switch_value   (req_switch_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_controller (rsp_out_controller),
      .rsp_out_value      (rsp_out_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   fade_ramp_checker #(.TICK_RATE(TICK_RATE_DEF)) ramp_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_switch_value   (req_switch_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_controller (rsp_out_controller),
      .rsp_out_value      (rsp_out_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending),
      .results_checked    (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [6:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 7'd0;
         1:       return 7'd127;
         2:       return 7'd64;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [15:0] pick_ms();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom_range(0, 19));
         1:       return 16'd20;
         2:       return 16'hFFFF;
         3:       return rand16();
         default: return 16'($urandom_range(20, 45));
      endcase
   endfunction

   // result side: random stall after each item and now and then while idle
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            stall_left = draw_wait();
         else if (stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = draw_wait();
         @(negedge clock);
         rsp_stall = (stall_left > 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   task automatic push_item(logic op, logic [15:0] sw);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_operation    = op;
      req_switch_value = sw;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic settle();
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure_random();
      settle();
      write_reg(REG_CHANNEL, rand16());
      write_reg(REG_CONTROLLER, rand16());
      write_reg(REG_START, (rand16() & 16'hFF80) | 16'(pick_level()));
      write_reg(REG_HOLD, (rand16() & 16'hFF80) | 16'(pick_level()));
      write_reg(REG_END, (rand16() & 16'hFF80) | 16'(pick_level()));
      write_reg(REG_FADE_IN, pick_ms());
      write_reg(REG_FADE_OUT, pick_ms());
      if ($urandom_range(0, 3) == 0)
         write_reg(REG_UNUSED, rand16());
      setups++;
      calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0) begin
         noise_items++;
         if ($urandom_range(0, 1) == 0)
            push_item(OP_SWITCH, rand16());
         else
            push_item(OP_SWITCH, uut.req_switch_value);
      end
   endtask

   task automatic play_gesture();
      int k;
      maybe_noise();
      push_item(OP_SWITCH, SW_PRESS);
      k = $urandom_range(0, 30);
      repeat (k) push_item(OP_TICK, rand16());
      maybe_noise();
      push_item(OP_SWITCH, SW_RELEASE);
      k = $urandom_range(0, 30);
      repeat (k) push_item(OP_TICK, rand16());
      // stray value then a second release re-arms the fade-out with its old step
      if ($urandom_range(0, 7) == 0) begin
         noise_items++;
         push_item(OP_SWITCH, rand16() | 16'h0002);
         push_item(OP_SWITCH, SW_RELEASE);
         k = $urandom_range(1, 10);
         repeat (k) push_item(OP_TICK, rand16());
      end
      if ($urandom_range(0, 19) == 0)
         hold_until_drained();
   endtask

   initial begin
      int goal;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_TICK;
      req_switch_value = '0;
      csr_valid        = 1'b0;
      csr_index        = REG_CHANNEL;
      csr_data         = '0;
      calm             = 1'b0;
      items_sent       = 0;
      noise_items      = 0;
      setups           = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values: jump on fade-in and fade-out
      push_item(OP_TICK, 16'h0000);
      push_item(OP_SWITCH, SW_PRESS);
      push_item(OP_TICK, 16'hFFFF);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_SWITCH, SW_RELEASE);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_TICK, 16'h0000);
      hold_until_drained();

      // extremes: falling fade-in, slow rising fade-out, stored and repeated values
      settle();
      write_reg(REG_CHANNEL, 16'hFFFF);
      write_reg(REG_CONTROLLER, 16'hFFFF);
      write_reg(REG_START, 16'h007F);
      write_reg(REG_HOLD, 16'hFF80);
      write_reg(REG_END, 16'h007F);
      write_reg(REG_FADE_IN, 16'd20);
      write_reg(REG_FADE_OUT, 16'hFFFF);
      write_reg(REG_UNUSED, 16'h5555);
      setups++;
      push_item(OP_SWITCH, SW_PRESS);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_TICK, 16'hFFFF);
      push_item(OP_SWITCH, SW_RELEASE);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_SWITCH, 16'hFFFF);
      push_item(OP_SWITCH, 16'hFFFF);
      push_item(OP_SWITCH, SW_RELEASE);
      push_item(OP_TICK, 16'h0000);

      // start equal to hold, end equal to hold with a fade-out time above the minimum
      settle();
      write_reg(REG_CHANNEL, 16'h0000);
      write_reg(REG_CONTROLLER, 16'h0000);
      write_reg(REG_START, 16'd64);
      write_reg(REG_HOLD, 16'd64);
      write_reg(REG_END, 16'd64);
      write_reg(REG_FADE_IN, 16'd100);
      write_reg(REG_FADE_OUT, 16'd30);
      setups++;
      push_item(OP_SWITCH, SW_PRESS);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_SWITCH, SW_RELEASE);
      push_item(OP_TICK, 16'h0000);
      push_item(OP_TICK, 16'h0000);

      goal = items_sent - noise_items + GESTURE_ITEMS;
      while (items_sent - noise_items < goal) begin
         configure_random();
         repeat ($urandom_range(2, 4)) play_gesture();
      end

      settle();
      $display("sent %0d items over %0d register setups, %0d control changes checked",
               items_sent, setups, results_checked);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sfrg_pkg.sv
hdl/sfrg_div.sv
hdl/switch_fade_ramp_generator_core.sv
hdl/sfrg_checker.sv
tb/fade_ramp_checker.sv
tb/switch_fade_ramp_generator_core_tb.sv
